// ----- rtl/mlsc_pkg.sv -----
// Shared constants, register codes and word type for the mu-law segment codec.
package mlsc_pkg;

   localparam int CODE_BITS_DEFAULT = 8;

   localparam int SAMPLE_W    = 16;
   localparam int CODE_W      = 8;
   localparam int SCALE_W     = 15;
   localparam int MAG_W       = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE       = 2'd1;

   localparam logic MODE_COMPRESS = 1'b0;
   localparam logic MODE_EXPAND   = 1'b1;

   localparam logic [SCALE_W-1:0] FULL_SCALE_RESET = 15'h7FFF;
   localparam logic [SCALE_W-1:0] SAMPLE_MAG_MAX   = 15'h7FFF;

   localparam int PROD_W      = 23;
   localparam int DIVR_W      = 22;
   localparam int Z_W         = 23;
   localparam int Q_W         = 16;
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0] RECIP_255 = 25'h0101_0101;

   typedef struct packed {
      logic             expand;
      logic             neg;
      logic [MAG_W-1:0] val;
   } word_type;

endpackage

// ----- rtl/mlsc_front.sv -----
// Front stage: take input words, split sign and magnitude by mode, register the result.
module mlsc_front #(
   parameter int CODE_BITS = mlsc_pkg::CODE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  mode,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mlsc_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic        [mlsc_pkg::CODE_W-1:0]    req_code_in,
   output logic                                  word_valid,
   input  logic                                  word_ready,
   output mlsc_pkg::word_type                    word
);

   logic [CODE_BITS-1:0]          code_x;
   logic [mlsc_pkg::MAG_W-1:0]    mag;
   mlsc_pkg::word_type            word_in;
   mlsc_pkg::word_type            word_ff;
   logic                          valid_in;
   logic                          valid_ff;

   always_comb begin
      code_x = CODE_BITS'(req_code_in);
      mag = req_sample_in[mlsc_pkg::SAMPLE_W-1]
          ? mlsc_pkg::MAG_W'(17'h1_0000 - {1'b0, req_sample_in})
          : {1'b0, req_sample_in};
      word_in.expand = (mode == mlsc_pkg::MODE_EXPAND);
      if (mode == mlsc_pkg::MODE_EXPAND) begin
         word_in.neg = code_x[CODE_BITS-1];
         word_in.val = mlsc_pkg::MAG_W'(code_x[CODE_BITS-2:0]);
      end else begin
         word_in.neg = req_sample_in[mlsc_pkg::SAMPLE_W-1];
         word_in.val = mag;
      end
   end

   assign req_ready  = !valid_ff || word_ready;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         word_ff <= word_in;
      end
   end

endmodule

// ----- rtl/mlsc_queue.sv -----
// Short word queue between the front stage and the arithmetic back end.
module mlsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  mlsc_pkg::word_type in_word,
   output logic               out_valid,
   input  logic               out_ready,
   output mlsc_pkg::word_type out_word
);

   localparam int DEPTH = mlsc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mlsc_pkg::word_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

// ----- rtl/mlsc_back.sv -----
// Back end: compress and expand pipelines, equal length, with the result register.
module mlsc_back #(
   parameter int CODE_BITS = mlsc_pkg::CODE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [mlsc_pkg::SCALE_W-1:0]          full_scale,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  mlsc_pkg::word_type                    in_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [mlsc_pkg::CODE_W-1:0]    rsp_code_out,
   output logic signed [mlsc_pkg::SAMPLE_W-1:0]  rsp_sample_out
);

   localparam int STEP = 1 << (CODE_BITS - 4);
   localparam int NDIV = CODE_BITS - 4;
   localparam int CW   = CODE_BITS - 1;
   localparam int TW   = CODE_BITS + 5;
   localparam int YW   = CODE_BITS + 20;
   localparam int NC   = CODE_BITS - 1;
   localparam int NE   = 5;
   localparam int NS   = (NC > NE) ? NC : NE;
   localparam int PADC = NS - NC;
   localparam int PADE = NS - NE;
   localparam int Z_W_SUM = mlsc_pkg::Z_W + mlsc_pkg::RECIP_W;
   localparam int PW   = Z_W_SUM;

   localparam logic [TW-1:0] TWO_STEP  = TW'(2 * STEP);
   localparam logic [YW:0]   HALF_DEN  = (YW + 1)'(255 * STEP);
   localparam logic [CW-1:0] OFF_MASK  = CW'(STEP - 1);
   localparam logic [CW-1:0] MANT_BASE = CW'(2 * STEP + 1);

   logic en;

   // valid and direction line
   logic v_ff [NS];
   logic x_ff [NS];

   // compress path
   logic [mlsc_pkg::PROD_W-1:0]  c1_a_in, c1_a_ff;
   logic                         c1_sat_in, c1_sat_ff;
   logic                         c1_neg_ff;
   logic [mlsc_pkg::PROD_W-1:0]  th [8];
   logic [2:0]                   c2_seg_in, c2_seg_ff;
   logic [mlsc_pkg::PROD_W-1:0]  c2_a_ff;
   logic                         c2_sat_ff;
   logic                         c2_neg_ff;
   logic [mlsc_pkg::DIVR_W-1:0]  dr_in [NDIV+1];
   logic [mlsc_pkg::DIVR_W-1:0]  dr_ff [NDIV+1];
   logic [mlsc_pkg::DIVR_W-1:0]  dd_in [NDIV+1];
   logic [mlsc_pkg::DIVR_W-1:0]  dd_ff [NDIV+1];
   logic [CW-1:0]                dm_in [NDIV+1];
   logic [CW-1:0]                dm_ff [NDIV+1];
   logic                         dsat_ff [NDIV+1];
   logic                         dneg_ff [NDIV+1];
   logic [CODE_BITS-1:0]         c_code;
   logic [mlsc_pkg::CODE_W-1:0]  c_byte;
   logic [mlsc_pkg::CODE_W-1:0]  c_end;

   // expand path
   logic [CW-1:0]                e_num;
   logic [2:0]                   e_seg;
   logic [CW-1:0]                e_mant;
   logic [TW-1:0]                e1_t_in, e1_t_ff;
   logic                         e1_neg_ff;
   logic [YW-1:0]                e2_y_in, e2_y_ff;
   logic                         e2_neg_ff;
   logic [YW:0]                  e_ysum;
   logic [mlsc_pkg::Z_W-1:0]     e3_z_in, e3_z_ff;
   logic                         e3_neg_ff;
   logic [PW-1:0]                e_prod;
   logic [mlsc_pkg::Q_W-1:0]     e4_q_ff;
   logic [mlsc_pkg::Z_W-1:0]     e4_z_ff;
   logic                         e4_neg_ff;
   logic [mlsc_pkg::Z_W:0]       e_rem;
   logic [mlsc_pkg::Q_W:0]       e_qr;
   logic [mlsc_pkg::SCALE_W-1:0] e5_q_in, e5_q_ff;
   logic                         e5_neg_ff;
   logic [mlsc_pkg::SAMPLE_W-1:0] e_sample;
   logic [mlsc_pkg::SAMPLE_W-1:0] e_end;

   logic                          rsp_valid_ff;
   logic [mlsc_pkg::CODE_W-1:0]   rsp_code_ff;
   logic [mlsc_pkg::SAMPLE_W-1:0] rsp_sample_ff;

   assign en             = !rsp_valid_ff || rsp_ready;
   assign in_ready       = en;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_out   = rsp_code_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // compress: scale magnitude, find segment, divide out the offset
   always_comb begin
      c1_a_in   = mlsc_pkg::PROD_W'({in_word.val, 8'b0} - {8'b0, in_word.val});
      c1_sat_in = (in_word.val >= mlsc_pkg::MAG_W'(full_scale));
      for (int k = 0; k < 8; k++) begin
         th[k] = (mlsc_pkg::PROD_W'(full_scale) << k) - mlsc_pkg::PROD_W'(full_scale);
      end
      c2_seg_in = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (c1_a_ff >= th[k]) begin
            c2_seg_in = 3'(k);
         end
      end
   end

   always_comb begin
      logic [mlsc_pkg::DIVR_W:0] r2;
      logic                      ge;
      dr_in[0] = mlsc_pkg::DIVR_W'(c2_a_ff
               - ((mlsc_pkg::PROD_W'(full_scale) << c2_seg_ff)
               - mlsc_pkg::PROD_W'(full_scale)));
      dd_in[0] = mlsc_pkg::DIVR_W'(full_scale) << c2_seg_ff;
      dm_in[0] = CW'(c2_seg_ff);
      for (int i = 1; i <= NDIV; i++) begin
         r2 = {dr_ff[i-1], 1'b0};
         ge = (r2 >= {1'b0, dd_ff[i-1]});
         dr_in[i] = ge ? mlsc_pkg::DIVR_W'(r2 - {1'b0, dd_ff[i-1]})
                       : mlsc_pkg::DIVR_W'(r2);
         dd_in[i] = dd_ff[i-1];
         dm_in[i] = {dm_ff[i-1][CW-2:0], ge};
      end
      c_code = {dneg_ff[NDIV], dsat_ff[NDIV] ? {CW{1'b1}} : dm_ff[NDIV]};
      c_byte = mlsc_pkg::CODE_W'(c_code);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_a_ff    <= c1_a_in;
         c1_sat_ff  <= c1_sat_in;
         c1_neg_ff  <= in_word.neg;
         c2_seg_ff  <= c2_seg_in;
         c2_a_ff    <= c1_a_ff;
         c2_sat_ff  <= c1_sat_ff;
         c2_neg_ff  <= c1_neg_ff;
         dsat_ff[0] <= c2_sat_ff;
         dneg_ff[0] <= c2_neg_ff;
         for (int i = 0; i <= NDIV; i++) begin
            dr_ff[i] <= dr_in[i];
            dd_ff[i] <= dd_in[i];
            dm_ff[i] <= dm_in[i];
         end
         for (int i = 1; i <= NDIV; i++) begin
            dsat_ff[i] <= dsat_ff[i-1];
            dneg_ff[i] <= dneg_ff[i-1];
         end
      end
   end

   // expand: rebuild step midpoint, scale, round by reciprocal of 255
   always_comb begin
      e_num   = in_word.val[CW-1:0];
      e_seg   = e_num[CW-1 -: 3];
      e_mant  = MANT_BASE | ((e_num & OFF_MASK) << 1);
      e1_t_in = (TW'(e_mant) << e_seg) - TWO_STEP;
      e2_y_in = YW'(full_scale) * YW'(e1_t_ff);
      e_ysum  = {1'b0, e2_y_ff} + HALF_DEN;
      e3_z_in = mlsc_pkg::Z_W'(e_ysum >> (CODE_BITS - 3));
      e_prod  = PW'(e3_z_ff) * PW'(mlsc_pkg::RECIP_255);
      e_rem   = {1'b0, e4_z_ff} - ({e4_q_ff, 8'b0} - {8'b0, e4_q_ff});
      e_qr    = (e_rem >= (mlsc_pkg::Z_W + 1)'(255)) ? {1'b0, e4_q_ff} + 17'd1
                                                     : {1'b0, e4_q_ff};
      e5_q_in = (e_qr > (mlsc_pkg::Q_W + 1)'(mlsc_pkg::SAMPLE_MAG_MAX))
              ? mlsc_pkg::SAMPLE_MAG_MAX : mlsc_pkg::SCALE_W'(e_qr);
      e_sample = e5_neg_ff ? -{1'b0, e5_q_ff} : {1'b0, e5_q_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_t_ff   <= e1_t_in;
         e1_neg_ff <= in_word.neg;
         e2_y_ff   <= e2_y_in;
         e2_neg_ff <= e1_neg_ff;
         e3_z_ff   <= e3_z_in;
         e3_neg_ff <= e2_neg_ff;
         e4_q_ff   <= e_prod[mlsc_pkg::RECIP_SHIFT +: mlsc_pkg::Q_W];
         e4_z_ff   <= e3_z_ff;
         e4_neg_ff <= e3_neg_ff;
         e5_q_ff   <= e5_q_in;
         e5_neg_ff <= e4_neg_ff;
      end
   end

   // equalize path lengths
   if (PADC > 0) begin : g_cpad
      logic [mlsc_pkg::CODE_W-1:0] cpad_ff [PADC];
      always_ff @(posedge clock) begin
         if (en) begin
            cpad_ff[0] <= c_byte;
            for (int i = 1; i < PADC; i++) begin
               cpad_ff[i] <= cpad_ff[i-1];
            end
         end
      end
      assign c_end = cpad_ff[PADC-1];
   end else begin : g_cnopad
      assign c_end = c_byte;
   end

   if (PADE > 0) begin : g_epad
      logic [mlsc_pkg::SAMPLE_W-1:0] epad_ff [PADE];
      always_ff @(posedge clock) begin
         if (en) begin
            epad_ff[0] <= e_sample;
            for (int i = 1; i < PADE; i++) begin
               epad_ff[i] <= epad_ff[i-1];
            end
         end
      end
      assign e_end = epad_ff[PADE-1];
   end else begin : g_enopad
      assign e_end = e_sample;
   end

   // valid line and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            v_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
         rsp_valid_ff <= v_ff[NS-1];
      end
      if (en) begin
         x_ff[0] <= in_word.expand;
         for (int i = 1; i < NS; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         rsp_code_ff   <= x_ff[NS-1] ? '0 : c_end;
         rsp_sample_ff <= x_ff[NS-1] ? e_end : '0;
      end
   end

endmodule

// ----- rtl/mu_law_segment_codec_top.sv -----
// Top level of the mu-law segment codec: register port, front stage, queue and back end.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   req      | req_valid / req_ready | req_sample_in, req_code_in
//   rsp      | rsp_valid / rsp_ready | rsp_code_out, rsp_sample_out
//   csr      | csr_valid / csr_ready | csr_index, csr_data
//
// One word per cycle in and out while rsp_ready keeps taking results. The path is the
// front register, the queue, max(CODE_BITS-1, 5) back-end stages (the offset divider
// takes one quotient bit per stage) and the result register.
// Synchronous reset clears all control state.
// A held result freezes the back end; the queue and front stage keep taking words until full.
module mu_law_segment_codec_top #(
   parameter int CODE_BITS = mlsc_pkg::CODE_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [mlsc_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic        [mlsc_pkg::CODE_W-1:0]     req_code_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic        [mlsc_pkg::CODE_W-1:0]     rsp_code_out,
   output logic signed [mlsc_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [mlsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [mlsc_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [mlsc_pkg::SCALE_W-1:0] full_scale_ff, full_scale_in;
   logic                         mode_ff, mode_in;
   logic [mlsc_pkg::SCALE_W-1:0] scale_eff;

   logic                         front_valid;
   logic                         front_ready;
   mlsc_pkg::word_type           front_word;
   logic                         back_valid;
   logic                         back_ready;
   mlsc_pkg::word_type           back_word;

   assign csr_ready = 1'b1;

   always_comb begin
      full_scale_in = full_scale_ff;
      mode_in       = mode_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mlsc_pkg::CSR_FULL_SCALE: full_scale_in = mlsc_pkg::SCALE_W'(csr_data);
            mlsc_pkg::CSR_MODE:       mode_in       = csr_data[0];
            default: begin
            end
         endcase
      end
      scale_eff = (full_scale_ff == '0) ? mlsc_pkg::SCALE_W'(1) : full_scale_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= mlsc_pkg::FULL_SCALE_RESET;
         mode_ff       <= mlsc_pkg::MODE_COMPRESS;
      end else begin
         full_scale_ff <= full_scale_in;
         mode_ff       <= mode_in;
      end
   end

   mlsc_front #(
      .CODE_BITS (CODE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .req_code_in   (req_code_in),
      .word_valid    (front_valid),
      .word_ready    (front_ready),
      .word          (front_word)
   );

   mlsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_word  (back_word)
   );

   mlsc_back #(
      .CODE_BITS (CODE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .full_scale     (scale_eff),
      .in_valid       (back_valid),
      .in_ready       (back_ready),
      .in_word        (back_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_out   (rsp_code_out),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// ----- sim/mu_law_segment_codec_top_tb.sv -----
// Testbench for the mu-law segment codec top: directed and random words checked against a predictor.
module mu_law_segment_codec_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CODE_BITS  = mlsc_pkg::CODE_BITS_DEFAULT;
   localparam int CODE_M     = 1 << (CODE_BITS - 1);
   localparam int SEG_SHIFT  = CODE_BITS - 4;
   localparam int EXP_DEN    = 510 * CODE_M;
   localparam int LATENCY    = 10;
   localparam int SETTLE     = LATENCY + 2;
   localparam int MAX_CYCLES = 400000;
   localparam int N_RANDOM   = 585;

   localparam logic [mlsc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [mlsc_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [mlsc_pkg::CODE_W-1:0]   code;
      logic [mlsc_pkg::SAMPLE_W-1:0] sample;
   } codec_word_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic signed [mlsc_pkg::SAMPLE_W-1:0]    req_sample_in = '0;
   logic        [mlsc_pkg::CODE_W-1:0]      req_code_in = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic        [mlsc_pkg::CODE_W-1:0]      rsp_code_out;
   logic signed [mlsc_pkg::SAMPLE_W-1:0]    rsp_sample_out;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic        [mlsc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic        [mlsc_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   logic [mlsc_pkg::SCALE_W-1:0] scale_reg;
   logic                         mode_reg;
   codec_word_type               due_words[$];

   int send_idle_pct = 7;
   int recv_idle_pct = 57;
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   int csr_writes = 0;
   int compress_words = 0;
   int expand_words = 0;
   int cycle_count = 0;

   mu_law_segment_codec_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_code_in    (req_code_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_out   (rsp_code_out),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("mu_law_segment_codec_top_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic longint unsigned scale_eff();
      return (scale_reg == 0) ? 64'd1 : 64'(scale_reg);
   endfunction

   function automatic logic [mlsc_pkg::CODE_W-1:0] mu_compress(
         logic [mlsc_pkg::SAMPLE_W-1:0] raw);
      longint unsigned f, mag, num, den, code;
      int seg;
      f = scale_eff();
      mag = raw[mlsc_pkg::SAMPLE_W-1] ? (64'd65536 - 64'(raw)) : 64'(raw);
      if (mag >= f) begin
         code = CODE_M - 1;
      end else begin
         seg = 0;
         for (int k = 1; k <= 7; k++) begin
            if (255 * mag >= ((64'd1 << k) - 1) * f) seg = k;
         end
         num = (255 * mag - ((64'd1 << seg) - 1) * f) * CODE_M;
         den = f * 8 * (64'd1 << seg);
         code = CODE_M * seg / 8 + num / den;
         if (code > CODE_M - 1) code = CODE_M - 1;
      end
      if (raw[mlsc_pkg::SAMPLE_W-1]) code = code | CODE_M;
      return code[mlsc_pkg::CODE_W-1:0];
   endfunction

   function automatic logic [mlsc_pkg::SAMPLE_W-1:0] mu_expand(
         logic [mlsc_pkg::CODE_W-1:0] code);
      longint unsigned f, mag, seg, base, p, numer, q, r;
      f = scale_eff();
      mag = 64'(code) & (CODE_M - 1);
      seg = (mag >> SEG_SHIFT) & 7;
      base = CODE_M * seg / 8;
      p = 64'd1 << seg;
      numer = f * ((p - 1) * 2 * CODE_M + (2 * (mag - base) + 1) * 8 * p);
      q = numer / EXP_DEN;
      r = numer % EXP_DEN;
      if (2 * r >= EXP_DEN) q = q + 1;
      if (q > 32767) q = 32767;
      if (code[CODE_BITS-1]) q = 64'd65536 - q;
      return q[mlsc_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic codec_word_type companded_result(
         logic [mlsc_pkg::SAMPLE_W-1:0] sample, logic [mlsc_pkg::CODE_W-1:0] code);
      codec_word_type w;
      if (mode_reg == mlsc_pkg::MODE_COMPRESS) begin
         w.code = mu_compress(sample);
         w.sample = '0;
      end else begin
         w.code = '0;
         w.sample = mu_expand(code);
      end
      return w;
   endfunction

   function automatic logic [mlsc_pkg::SAMPLE_W-1:0] pick_sample();
      longint unsigned f, mag;
      int k;
      f = scale_eff();
      k = $urandom_range(1, 7);
      case ($urandom_range(3))
         0: return mlsc_pkg::SAMPLE_W'($urandom());
         1: mag = $urandom_range(0, int'(f) + 2);
         2: mag = ((64'd1 << k) - 1) * f / 255 + $urandom_range(0, 2);
         default: mag = $urandom_range(1) ? 64'd32768 : 64'd32767;
      endcase
      if ($urandom_range(1)) begin
         return mlsc_pkg::SAMPLE_W'(64'd65536 - mag);
      end
      if (mag > 32767) mag = 32767;
      return mlsc_pkg::SAMPLE_W'(mag);
   endfunction

   always @(posedge clock) begin
      codec_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            errors++;
            $display("%0t unexpected word: expected none, actual code %02h sample %04h",
                     $time, rsp_code_out, rsp_sample_out);
         end else begin
            want = due_words.pop_front();
            words_checked++;
            if (rsp_code_out !== want.code) begin
               errors++;
               $display("%0t code_out mismatch: expected %02h actual %02h",
                        $time, want.code, rsp_code_out);
            end
            if (rsp_sample_out !== want.sample) begin
               errors++;
               $display("%0t sample_out mismatch: expected %04h actual %04h",
                        $time, want.sample, rsp_sample_out);
            end
         end
      end
   end

   task automatic send_word(logic [mlsc_pkg::SAMPLE_W-1:0] sample,
                            logic [mlsc_pkg::CODE_W-1:0] code);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_sample_in <= sample;
      req_code_in <= code;
      do @(posedge clock); while (!req_ready);
      due_words.insert(due_words.size(), companded_result(sample, code));
      words_sent++;
      if (mode_reg == mlsc_pkg::MODE_COMPRESS) compress_words++;
      else expand_words++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [mlsc_pkg::CSR_INDEX_W-1:0] index,
                            logic [mlsc_pkg::CSR_DATA_W-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (index)
         mlsc_pkg::CSR_FULL_SCALE: scale_reg = data[mlsc_pkg::SCALE_W-1:0];
         mlsc_pkg::CSR_MODE:       mode_reg = data[0];
         default: ;
      endcase
   endtask

   task automatic test_compress_edges();
      int t;
      write_csr(mlsc_pkg::CSR_FULL_SCALE, mlsc_pkg::SAMPLE_MAG_MAX);
      write_csr(mlsc_pkg::CSR_MODE, mlsc_pkg::CSR_DATA_W'(mlsc_pkg::MODE_COMPRESS));
      send_word(16'sd0, 8'h00);
      send_word(16'sd1, 8'hFF);
      send_word(-16'sd1, 8'h00);
      send_word(16'sd32767, 8'hFF);
      send_word(-16'sd32768, 8'h00);
      send_word(16'sd32766, 8'hFF);
      send_word(-16'sd32767, 8'h00);
      for (int k = 1; k <= 7; k += 3) begin
         t = ((1 << k) - 1) * 32767 / 255;
         send_word(mlsc_pkg::SAMPLE_W'(t), mlsc_pkg::CODE_W'($urandom_range(255)));
         send_word(mlsc_pkg::SAMPLE_W'(-(t + 1)), mlsc_pkg::CODE_W'($urandom_range(255)));
      end
   endtask

   task automatic test_compress_small_scale();
      write_csr(mlsc_pkg::CSR_FULL_SCALE, 15'd1);
      send_word(16'sd0, 8'h00);
      send_word(16'sd1, 8'h00);
      send_word(-16'sd32768, 8'h00);
      write_csr(mlsc_pkg::CSR_FULL_SCALE, 15'd0);
      send_word(16'sd0, 8'hFF);
      send_word(-16'sd1, 8'hFF);
      write_csr(mlsc_pkg::CSR_FULL_SCALE, 15'd1000);
      send_word(16'sd999, 8'h00);
      send_word(-16'sd1000, 8'h00);
   endtask

   task automatic test_expand_edges();
      write_csr(mlsc_pkg::CSR_MODE, mlsc_pkg::CSR_DATA_W'(mlsc_pkg::MODE_EXPAND));
      write_csr(mlsc_pkg::CSR_FULL_SCALE, mlsc_pkg::SAMPLE_MAG_MAX);
      send_word(16'sh7FFF, 8'h00);
      send_word(16'sh8000, 8'h0F);
      send_word(16'sh0000, 8'h10);
      send_word(16'shFFFF, 8'h7F);
      send_word(16'sh5555, 8'h80);
      send_word(16'shAAAA, 8'hFF);
      write_csr(mlsc_pkg::CSR_FULL_SCALE, 15'd4080);
      send_word(16'sh0000, 8'h00);
      send_word(16'sh0000, 8'h80);
      write_csr(mlsc_pkg::CSR_FULL_SCALE, 15'd1);
      send_word(16'sh0000, 8'h7F);
      send_word(16'sh0000, 8'hFF);
   endtask

   task automatic test_spare_index();
      write_csr(CSR_SPARE_LO, 15'h7FFF);
      write_csr(CSR_SPARE_HI, 15'h2AAA);
      write_csr(mlsc_pkg::CSR_MODE, 15'h7FFE);
      send_word(16'sh4000, 8'h00);
      send_word(16'shC000, 8'hFF);
   endtask

   task automatic test_random_stream(int n_words, int s_pct, int r_pct);
      int sent;
      int batch;
      logic [mlsc_pkg::CSR_DATA_W-1:0] scale;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < n_words) begin
         case ($urandom_range(5))
            0: scale = 15'd1;
            1: scale = 15'h7FFF;
            2: scale = 15'd0;
            3: scale = mlsc_pkg::CSR_DATA_W'($urandom_range(2, 255));
            default: scale = mlsc_pkg::CSR_DATA_W'($urandom_range(1, 32767));
         endcase
         write_csr(mlsc_pkg::CSR_FULL_SCALE, scale);
         write_csr(mlsc_pkg::CSR_MODE, mlsc_pkg::CSR_DATA_W'($urandom_range(0, 32767)));
         batch = $urandom_range(10, 40);
         repeat (batch) begin
            send_word(pick_sample(), mlsc_pkg::CODE_W'($urandom_range(255)));
         end
         sent += batch;
      end
   endtask

   initial begin
      scale_reg = mlsc_pkg::FULL_SCALE_RESET;
      mode_reg = mlsc_pkg::MODE_COMPRESS;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_compress_edges();
      test_compress_small_scale();
      test_expand_edges();
      test_spare_index();
      test_random_stream(N_RANDOM / 3, 7, 57);
      test_random_stream(N_RANDOM / 3, 57, 7);
      test_random_stream(N_RANDOM / 3, 0, 0);
      drain();
      $display("%0d words sent (%0d compress, %0d expand), %0d checked, %0d register writes",
               words_sent, compress_words, expand_words, words_checked, csr_writes);
      if (errors == 0) begin
         $display("mu_law_segment_codec_top_tb: done, clean");
      end else begin
         $display("mu_law_segment_codec_top_tb: done, errors");
      end
      $finish;
   end

endmodule
